/* rtl/core/hsv2rgb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared types and fixed-point constants of the hsv to rgb pipeline
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // hue in 1/64 degree units
  localparam logic signed [16:0] HueLow  = -17'sd23040;
  localparam logic signed [16:0] HueHigh = 17'sd46079;
  localparam logic [16:0]        HueFull = 17'd23040;
  localparam logic [14:0]        HueSect = 15'd3840;

  // saturation and value in 1/1024 units
  localparam logic [10:0] UnitOne = 11'd1024;

  // floor(n / 15) as (n * Div15Mul) >> Div15Shift, exact for n below 23831
  localparam logic [14:0] Div15Mul   = 15'd17477;
  localparam int unsigned Div15Shift = 18;

  // hue sectors
  localparam logic [2:0] SectRedYel = 3'd0;
  localparam logic [2:0] SectYelGrn = 3'd1;
  localparam logic [2:0] SectGrnCyn = 3'd2;
  localparam logic [2:0] SectCynBlu = 3'd3;
  localparam logic [2:0] SectBluMag = 3'd4;
  localparam logic [2:0] SectMagRed = 3'd5;

  typedef struct packed {
    logic signed [16:0] hue_q6;
    logic signed [11:0] sat_q10;
    logic signed [11:0] val_q10;
  } hsv_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_rsp_t;

  // after hue reduction and clamping
  typedef struct packed {
    logic [14:0] hue;
    logic [10:0] sat;
    logic [10:0] val;
  } prep_t;

  // after the chroma product and the sector split
  typedef struct packed {
    logic [10:0] chroma;
    logic [10:0] val;
    logic [2:0]  sector;
    logic [11:0] frac;
  } chroma_t;

  // after the position product
  typedef struct packed {
    logic [21:0] pos_prod;
    logic [10:0] chroma;
    logic [10:0] match;
    logic [2:0]  sector;
  } prod_t;

endpackage
`default_nettype wire

/* rtl/core/hsv2rgb_prep.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_prep
// stage 1: hue saturation and reduction into one turn, clamping of s and v
// ----------------------------------------------------------------------------
module hsv2rgb_prep (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire hsv2rgb_pkg::hsv_req_t req_i,
  output logic                       ready_o,
  output logic                       valid_o,
  output hsv2rgb_pkg::prep_t         data_o,
  input  wire logic                  ready_i
);

  function automatic logic [10:0] clamp_unit(logic signed [11:0] raw);
    logic [10:0] res;
    if (raw[11]) begin
      res = '0;
    end else if (raw[10:0] > hsv2rgb_pkg::UnitOne) begin
      res = hsv2rgb_pkg::UnitOne;
    end else begin
      res = raw[10:0];
    end
    return res;
  endfunction

  logic               valid_q;
  hsv2rgb_pkg::prep_t data_d, data_q;
  logic signed [16:0] hue_sat;
  logic [16:0]        hue_0, hue_1, hue_2;

  always_comb begin
    if (req_i.hue_q6 < hsv2rgb_pkg::HueLow) begin
      hue_sat = hsv2rgb_pkg::HueLow;
    end else if (req_i.hue_q6 > hsv2rgb_pkg::HueHigh) begin
      hue_sat = hsv2rgb_pkg::HueHigh;
    end else begin
      hue_sat = req_i.hue_q6;
    end
    // shift by one turn, result lies in 0 .. three turns
    hue_0 = $unsigned(hue_sat) + hsv2rgb_pkg::HueFull;
    hue_1 = (hue_0 >= hsv2rgb_pkg::HueFull) ? hue_0 - hsv2rgb_pkg::HueFull : hue_0;
    hue_2 = (hue_1 >= hsv2rgb_pkg::HueFull) ? hue_1 - hsv2rgb_pkg::HueFull : hue_1;
    data_d.hue = hue_2[14:0];
    data_d.sat = clamp_unit(req_i.sat_q10);
    data_d.val = clamp_unit(req_i.val_q10);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* rtl/core/hsv2rgb_chroma.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_chroma
// stages 2 and 3: chroma product, sector split, position-in-sector product
// ----------------------------------------------------------------------------
module hsv2rgb_chroma (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire hsv2rgb_pkg::prep_t  data_i,
  output logic                     ready_o,
  output logic                     valid_o,
  output hsv2rgb_pkg::prod_t       data_o,
  input  wire logic                ready_i
);

  localparam logic [14:0] Bound1 = hsv2rgb_pkg::HueSect;
  localparam logic [14:0] Bound2 = 15'(2 * hsv2rgb_pkg::HueSect);
  localparam logic [14:0] Bound3 = 15'(3 * hsv2rgb_pkg::HueSect);
  localparam logic [14:0] Bound4 = 15'(4 * hsv2rgb_pkg::HueSect);
  localparam logic [14:0] Bound5 = 15'(5 * hsv2rgb_pkg::HueSect);

  logic                 s2_valid_q, s3_valid_q, s3_ready;
  hsv2rgb_pkg::chroma_t s2_d, s2_q;
  hsv2rgb_pkg::prod_t   s3_d, s3_q;
  logic [21:0]          vs_prod;
  logic [14:0]          sect_base, frac_wide;
  logic [11:0]          pos;

  // stage 2
  always_comb begin
    vs_prod = {11'd0, data_i.val} * {11'd0, data_i.sat};
    if (data_i.hue < Bound1) begin
      s2_d.sector = hsv2rgb_pkg::SectRedYel;
      sect_base   = '0;
    end else if (data_i.hue < Bound2) begin
      s2_d.sector = hsv2rgb_pkg::SectYelGrn;
      sect_base   = Bound1;
    end else if (data_i.hue < Bound3) begin
      s2_d.sector = hsv2rgb_pkg::SectGrnCyn;
      sect_base   = Bound2;
    end else if (data_i.hue < Bound4) begin
      s2_d.sector = hsv2rgb_pkg::SectCynBlu;
      sect_base   = Bound3;
    end else if (data_i.hue < Bound5) begin
      s2_d.sector = hsv2rgb_pkg::SectBluMag;
      sect_base   = Bound4;
    end else begin
      s2_d.sector = hsv2rgb_pkg::SectMagRed;
      sect_base   = Bound5;
    end
    frac_wide   = data_i.hue - sect_base;
    s2_d.frac   = frac_wide[11:0];
    s2_d.chroma = vs_prod[20:10];
    s2_d.val    = data_i.val;
  end

  // stage 3: falling ramp on odd sectors
  always_comb begin
    pos = s2_q.sector[0] ? hsv2rgb_pkg::HueSect[11:0] - s2_q.frac : s2_q.frac;
    s3_d.pos_prod = 22'({11'd0, s2_q.chroma} * {10'd0, pos});
    s3_d.chroma   = s2_q.chroma;
    s3_d.match    = s2_q.val - s2_q.chroma;
    s3_d.sector   = s2_q.sector;
  end

  assign s3_ready = !s3_valid_q || ready_i;
  assign ready_o  = !s2_valid_q || s3_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        s2_valid_q <= valid_i;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      s2_q <= s2_d;
    end
    if (s3_ready) begin
      s3_q <= s3_d;
    end
  end

  assign valid_o = s3_valid_q;
  assign data_o  = s3_q;

endmodule
`default_nettype wire

/* rtl/core/hsv2rgb_mix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// stages 4 and 5: ramp scaling by one sector, channel routing and 8-bit scale
// ----------------------------------------------------------------------------
module hsv2rgb_mix (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire hsv2rgb_pkg::prod_t  data_i,
  output logic                     ready_o,
  output logic                     valid_o,
  output hsv2rgb_pkg::rgb_rsp_t    rsp_o,
  input  wire logic                ready_i
);

  typedef struct packed {
    logic [10:0] ramp;
    logic [10:0] chroma;
    logic [10:0] match;
    logic [2:0]  sector;
  } ramp_t;

  // floor(level * 255 / 1024), level at most 1024
  function automatic logic [7:0] to_chan(logic [10:0] level);
    logic [18:0] scaled;
    scaled = {level, 8'd0} - {8'd0, level};
    return scaled[17:10];
  endfunction

  logic                  s4_valid_q, s5_valid_q, s5_ready;
  ramp_t                 s4_d, s4_q;
  hsv2rgb_pkg::rgb_rsp_t s5_d, s5_q;
  logic [13:0]           quot256;
  logic [28:0]           recip_prod;
  logic [10:0]           comp_r, comp_g, comp_b;

  // stage 4: divide by one sector as >> 8 then / 15
  always_comb begin
    quot256     = data_i.pos_prod[21:8];
    recip_prod  = 29'({15'd0, quot256} * {14'd0, hsv2rgb_pkg::Div15Mul});
    s4_d.ramp   = recip_prod[hsv2rgb_pkg::Div15Shift +: 11];
    s4_d.chroma = data_i.chroma;
    s4_d.match  = data_i.match;
    s4_d.sector = data_i.sector;
  end

  // stage 5
  always_comb begin
    case (s4_q.sector)
      hsv2rgb_pkg::SectRedYel: begin
        comp_r = s4_q.chroma; comp_g = s4_q.ramp;   comp_b = '0;
      end
      hsv2rgb_pkg::SectYelGrn: begin
        comp_r = s4_q.ramp;   comp_g = s4_q.chroma; comp_b = '0;
      end
      hsv2rgb_pkg::SectGrnCyn: begin
        comp_r = '0;          comp_g = s4_q.chroma; comp_b = s4_q.ramp;
      end
      hsv2rgb_pkg::SectCynBlu: begin
        comp_r = '0;          comp_g = s4_q.ramp;   comp_b = s4_q.chroma;
      end
      hsv2rgb_pkg::SectBluMag: begin
        comp_r = s4_q.ramp;   comp_g = '0;          comp_b = s4_q.chroma;
      end
      default: begin
        comp_r = s4_q.chroma; comp_g = '0;          comp_b = s4_q.ramp;
      end
    endcase
    s5_d.red   = to_chan(comp_r + s4_q.match);
    s5_d.green = to_chan(comp_g + s4_q.match);
    s5_d.blue  = to_chan(comp_b + s4_q.match);
  end

  assign s5_ready = !s5_valid_q || ready_i;
  assign ready_o  = !s4_valid_q || s5_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        s4_valid_q <= valid_i;
      end
      if (s5_ready) begin
        s5_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      s4_q <= s4_d;
    end
    if (s5_ready) begin
      s5_q <= s5_d;
    end
  end

  assign valid_o = s5_valid_q;
  assign rsp_o   = s5_q;

endmodule
`default_nettype wire

/* rtl/core/hsv_to_rgb_converter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// pixel-rate hsv to 8-bit rgb converter, five register stages
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        sink       in_valid_i/in_stall_o  in_req_i   (hsv_req_t)
//  out       source     out_valid_o/out_stall_i out_rsp_o (rgb_rsp_t)
//
// one request per clock sustained while out_stall_i stays low
// the five stages in order: reduce, chroma/sector, ramp product,
// ramp divide, channel scale
// reset clears only the stage valid bits, no state survives between requests
// a stall on the output fills empty stages first, so in_stall_o rises only
// once every stage holds a request
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire hsv2rgb_pkg::hsv_req_t in_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output hsv2rgb_pkg::rgb_rsp_t      out_rsp_o
);

  // ready chain runs back from the output register to the input
  logic               prep_ready, chroma_ready, mix_ready;
  logic               prep_valid, chroma_valid;
  hsv2rgb_pkg::prep_t prep_data;
  hsv2rgb_pkg::prod_t chroma_data;

  // stage 1: hue into one turn, clamp saturation and value
  hsv2rgb_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .ready_o (prep_ready),
    .valid_o (prep_valid),
    .data_o  (prep_data),
    .ready_i (chroma_ready)
  );

  // stages 2 and 3: chroma, sector, position product
  hsv2rgb_chroma u_chroma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .data_i  (prep_data),
    .ready_o (chroma_ready),
    .valid_o (chroma_valid),
    .data_o  (chroma_data),
    .ready_i (mix_ready)
  );

  // stages 4 and 5: ramp value, routing, 8-bit channels (output register)
  hsv2rgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chroma_valid),
    .data_i  (chroma_data),
    .ready_o (mix_ready),
    .valid_o (out_valid_o),
    .rsp_o   (out_rsp_o),
    .ready_i (!out_stall_i)
  );

  assign in_stall_o = !prep_ready;

endmodule
`default_nettype wire

/* rtl/core/hsv2rgb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// port-level checks of the hsv to rgb converter, bound to the top level
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire hsv2rgb_pkg::hsv_req_t in_req_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire hsv2rgb_pkg::rgb_rsp_t out_rsp_o
);

  logic       in_acc;
  logic       run5;
  logic [4:0] acc_hist_q;
  logic [3:0] stall_hist_q;

  assign in_acc = in_valid_i && !in_stall_o;

  // acceptance and output stall history, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_hist_q   <= '0;
      stall_hist_q <= '0;
    end else begin
      acc_hist_q   <= {acc_hist_q[3:0], in_acc};
      stall_hist_q <= {stall_hist_q[2:0], out_stall_i};
    end
  end

  // oldest tap of acc_hist_q holds an acceptance after reset, and no output stall since
  assign run5 = acc_hist_q[4] && !(|stall_hist_q);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("stalled result changed");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run5 |-> out_valid_o)
    else $error("result missing after five unstalled cycles");

  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run5 && ($past(in_req_i.sat_q10[11], 5) || $past(in_req_i.sat_q10, 5) == 12'sd0)
    |-> (out_rsp_o.red == out_rsp_o.green) && (out_rsp_o.green == out_rsp_o.blue))
    else $error("zero saturation gave a non-grey result");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run5 && ($past(in_req_i.val_q10[11], 5) || $past(in_req_i.val_q10, 5) == 12'sd0)
    |-> (out_rsp_o.red == 8'd0) && (out_rsp_o.green == 8'd0) && (out_rsp_o.blue == 8'd0))
    else $error("zero value gave a non-black result");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (.*);
`default_nettype wire
